// ----- rtl/nbc_pkg.sv -----
`timescale 1ns / 1ps

package nbc_pkg;

  localparam int DEF_DIM_BITS  = 16;
  localparam int DEF_FRAC_BITS = 16;

  localparam int COORD_W  = 48;
  localparam int INV_W    = 48;
  localparam int INV_FRAC = 24;
  localparam int HALF_W   = COORD_W / 2;
  localparam int PROD_W   = COORD_W + INV_W;
  localparam int CELL_W   = 32;
  localparam int CFG_W    = 48;
  localparam int ADDR_W   = 3;
  localparam int STAGES   = 8;
  localparam int AXIS_STAGES = 6;

  localparam logic [INV_W-1:0] INV_ONE = 48'h000001000000;

  typedef enum logic [ADDR_W-1:0] {
    REG_NUM_COLS    = 3'd0,
    REG_NUM_ROWS    = 3'd1,
    REG_X_ORIGIN    = 3'd2,
    REG_Y_TOP       = 3'd3,
    REG_X_INV_RES   = 3'd4,
    REG_Y_INV_RES   = 3'd5,
    REG_ALLOW_DUP   = 3'd6,
    REG_GLOBAL_WRAP = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_DOWN,
    DIR_STAY,
    DIR_UP
  } dir_t;

endpackage

// ----- rtl/nbc_axis.sv -----
`timescale 1ns / 1ps

module nbc_axis #(
  parameter int DIM_BITS  = nbc_pkg::DEF_DIM_BITS,
  parameter int FRAC_BITS = nbc_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic [nbc_pkg::AXIS_STAGES-1:0]    en,
  input  logic signed [nbc_pkg::COORD_W-1:0] minuend,
  input  logic signed [nbc_pkg::COORD_W-1:0] subtrahend,
  input  logic [nbc_pkg::INV_W-1:0]          inv_res,
  input  logic [DIM_BITS-1:0]                size,
  input  logic                               wrap,
  input  logic                               allow_dup,
  output logic                               ok,
  output logic [DIM_BITS-1:0]                near,
  output logic [DIM_BITS-1:0]                nbr
);

  localparam int CW = nbc_pkg::COORD_W;
  localparam int HW = nbc_pkg::HALF_W;
  localparam int PW = nbc_pkg::PROD_W;
  localparam int LO = nbc_pkg::INV_FRAC + FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

  logic signed [CW:0]    diff;
  logic                  neg2, neg3, neg4;
  logic [CW-1:0]         mag;
  logic [2*HW-1:0]       pp00, pp01, pp10, pp11;
  logic [PW-1:0]         prod;
  logic                  ok5;
  logic [DIM_BITS-1:0]   rnd5;
  nbc_pkg::dir_t         dir5;
  logic [DIM_BITS-1:0]   idx;
  logic [FRAC_BITS-1:0]  frac;
  logic [DIM_BITS-1:0]   nbr_next;
  nbc_pkg::dir_t         dir_next;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      diff <= {minuend[CW-1], minuend} - {subtrahend[CW-1], subtrahend};
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg2 <= diff[CW];
      mag  <= CW'(diff[CW] ? -diff : diff);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      neg3 <= neg2;
      pp00 <= mag[HW-1:0]  * inv_res[HW-1:0];
      pp01 <= mag[HW-1:0]  * inv_res[CW-1:HW];
      pp10 <= mag[CW-1:HW] * inv_res[HW-1:0];
      pp11 <= mag[CW-1:HW] * inv_res[CW-1:HW];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      neg4 <= neg3;
      prod <= PW'(pp00) + ((PW'(pp01) + PW'(pp10)) << HW) + (PW'(pp11) << CW);
    end
  end

  // The scaled value is prod / 2^INV_FRAC with FRAC_BITS fraction bits; the
  // rounded index is its integer part plus one.
  assign idx  = prod[LO +: DIM_BITS];
  assign frac = prod[nbc_pkg::INV_FRAC +: FRAC_BITS];

  always_comb begin
    if (frac > HALF) begin
      dir_next = nbc_pkg::DIR_UP;
    end else if (frac < HALF) begin
      dir_next = nbc_pkg::DIR_DOWN;
    end else begin
      dir_next = allow_dup ? nbc_pkg::DIR_STAY : nbc_pkg::DIR_UP;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ok5  <= (!neg4 || prod == '0) && (prod[PW-1:LO+DIM_BITS] == '0) && (idx < size);
      rnd5 <= idx + DIM_BITS'(1);
      dir5 <= dir_next;
    end
  end

  always_comb begin
    unique case (dir5)
      nbc_pkg::DIR_UP: begin
        if (rnd5 == size) begin
          nbr_next = wrap ? DIM_BITS'(1) : size - DIM_BITS'(1);
        end else begin
          nbr_next = rnd5 + DIM_BITS'(1);
        end
      end
      nbc_pkg::DIR_DOWN: begin
        if (rnd5 == DIM_BITS'(1)) begin
          nbr_next = wrap ? size : DIM_BITS'(2);
        end else begin
          nbr_next = rnd5 - DIM_BITS'(1);
        end
      end
      nbc_pkg::DIR_STAY: nbr_next = rnd5;
      default:           nbr_next = rnd5;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      ok   <= ok5;
      near <= rnd5;
      nbr  <= nbr_next;
    end
  end

endmodule

// ----- rtl/nbc_cell.sv -----
`timescale 1ns / 1ps

module nbc_cell #(
  parameter int DIM_BITS = nbc_pkg::DEF_DIM_BITS
) (
  input  logic                         clk,
  input  logic [nbc_pkg::STAGES-nbc_pkg::AXIS_STAGES-1:0] en,
  input  logic                         ok_col,
  input  logic                         ok_row,
  input  logic [DIM_BITS-1:0]          rcol,
  input  logic [DIM_BITS-1:0]          pcol,
  input  logic [DIM_BITS-1:0]          rrow,
  input  logic [DIM_BITS-1:0]          prow,
  input  logic [DIM_BITS-1:0]          num_cols,
  output logic                         valid_res,
  output logic [nbc_pkg::CELL_W-1:0]   cell_nearest,
  output logic [nbc_pkg::CELL_W-1:0]   cell_vertical,
  output logic [nbc_pkg::CELL_W-1:0]   cell_diagonal,
  output logic [nbc_pkg::CELL_W-1:0]   cell_horizontal
);

  localparam int MW = 2 * DIM_BITS;
  localparam int SW = (MW > nbc_pkg::CELL_W) ? MW : nbc_pkg::CELL_W;

  logic                ok7;
  logic [MW-1:0]       mul_near, mul_nbr;
  logic [DIM_BITS-1:0] col_near, col_nbr;

  // Cell number (row - 1) * num_cols + col, modulo 2^32.
  function automatic logic [nbc_pkg::CELL_W-1:0] cell_num(
    input logic [MW-1:0]       m,
    input logic [DIM_BITS-1:0] n,
    input logic [DIM_BITS-1:0] c
  );
    logic [SW-1:0] s;
    s = SW'(m) - SW'(n) + SW'(c);
    return s[nbc_pkg::CELL_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ok7      <= ok_col && ok_row;
      mul_near <= rrow * num_cols;
      mul_nbr  <= prow * num_cols;
      col_near <= rcol;
      col_nbr  <= pcol;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      valid_res <= ok7;
      if (ok7) begin
        cell_nearest    <= cell_num(mul_near, num_cols, col_near);
        cell_vertical   <= cell_num(mul_nbr, num_cols, col_near);
        cell_diagonal   <= cell_num(mul_nbr, num_cols, col_nbr);
        cell_horizontal <= cell_num(mul_near, num_cols, col_nbr);
      end else begin
        cell_nearest    <= '0;
        cell_vertical   <= '0;
        cell_diagonal   <= '0;
        cell_horizontal <= '0;
      end
    end
  end

endmodule

// ----- rtl/four_neighbor_cells_from_point.sv -----
`timescale 1ns / 1ps

// Finds the nearest grid cell of a point and the three cells that complete
// the 2x2 block around it, as 1-based cell numbers for bilinear lookup.
// A point arrives as one request on the s_ channel; its result leaves as one
// request on the m_ channel, with m_tuser high when the nearest cell lies
// inside the grid and low (all cell numbers zero) when it does not.
// The grid geometry is set through cfg_we, cfg_addr and cfg_data; the user must
// write it only while no point is in flight, as the block does not enforce this.
// Reset loads a 2 by 2 grid at the origin with unit scale. The datapath is an
// eight-stage pipeline: the scale multiply is split into partial products and
// summed over two stages, and the cell numbers take a multiply stage and an add
// stage. A point moves through the stages in order and m_tvalid rises when it
// reaches the last; one point is accepted every cycle when the output is taken.
// When the receiver holds m_tready low, the pipeline keeps filling its empty
// stages and s_tready drops only once every stage holds a point.
// Reset clears all stage valid bits, so no result appears until new points
// are accepted.
module four_neighbor_cells_from_point #(
  parameter int DIM_BITS  = nbc_pkg::DEF_DIM_BITS,
  parameter int FRAC_BITS = nbc_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [2*nbc_pkg::COORD_W-1:0] s_tdata,  // x_coord, y_coord
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [4*nbc_pkg::CELL_W-1:0]  m_tdata,  // cell_nearest, cell_vertical,
                                                  // cell_diagonal, cell_horizontal
  output logic                          m_tuser,  // valid_res
  input  logic                          cfg_we,
  input  logic [nbc_pkg::ADDR_W-1:0]    cfg_addr,
  input  logic [nbc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CW = nbc_pkg::COORD_W;
  localparam int NS = nbc_pkg::STAGES;
  localparam int EW = nbc_pkg::CELL_W;
  localparam int AS = nbc_pkg::AXIS_STAGES;

  logic [DIM_BITS-1:0]   num_cols, num_rows;
  logic signed [CW-1:0]  x_origin, y_top;
  logic [nbc_pkg::INV_W-1:0] x_inv_res, y_inv_res;
  logic                  allow_duplicates, global_wrap;

  logic [NS-1:0]         stage_valid;
  logic [NS-1:0]         en;

  logic                  ok_col, ok_row;
  logic [DIM_BITS-1:0]   rcol, pcol, rrow, prow;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols         <= DIM_BITS'(2);
      num_rows         <= DIM_BITS'(2);
      x_origin         <= '0;
      y_top            <= '0;
      x_inv_res        <= nbc_pkg::INV_ONE;
      y_inv_res        <= nbc_pkg::INV_ONE;
      allow_duplicates <= 1'b1;
      global_wrap      <= 1'b0;
    end else if (cfg_we) begin
      unique case (nbc_pkg::reg_idx_t'(cfg_addr))
        nbc_pkg::REG_NUM_COLS:    num_cols         <= cfg_data[DIM_BITS-1:0];
        nbc_pkg::REG_NUM_ROWS:    num_rows         <= cfg_data[DIM_BITS-1:0];
        nbc_pkg::REG_X_ORIGIN:    x_origin         <= cfg_data[CW-1:0];
        nbc_pkg::REG_Y_TOP:       y_top            <= cfg_data[CW-1:0];
        nbc_pkg::REG_X_INV_RES:   x_inv_res        <= cfg_data[nbc_pkg::INV_W-1:0];
        nbc_pkg::REG_Y_INV_RES:   y_inv_res        <= cfg_data[nbc_pkg::INV_W-1:0];
        nbc_pkg::REG_ALLOW_DUP:   allow_duplicates <= cfg_data[0];
        nbc_pkg::REG_GLOBAL_WRAP: global_wrap      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    en[NS-1] = !stage_valid[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !stage_valid[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (en[0]) begin
        stage_valid[0] <= s_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = stage_valid[NS-1];

  nbc_axis #(
    .DIM_BITS (DIM_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_col (
    .clk       (clk),
    .en        (en[AS-1:0]),
    .minuend   (s_tdata[CW-1:0]),
    .subtrahend(x_origin),
    .inv_res   (x_inv_res),
    .size      (num_cols),
    .wrap      (global_wrap),
    .allow_dup (allow_duplicates),
    .ok        (ok_col),
    .near      (rcol),
    .nbr       (pcol)
  );

  nbc_axis #(
    .DIM_BITS (DIM_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_row (
    .clk       (clk),
    .en        (en[AS-1:0]),
    .minuend   (y_top),
    .subtrahend(s_tdata[2*CW-1:CW]),
    .inv_res   (y_inv_res),
    .size      (num_rows),
    .wrap      (1'b0),
    .allow_dup (allow_duplicates),
    .ok        (ok_row),
    .near      (rrow),
    .nbr       (prow)
  );

  nbc_cell #(
    .DIM_BITS(DIM_BITS)
  ) u_cell (
    .clk            (clk),
    .en             (en[NS-1:AS]),
    .ok_col         (ok_col),
    .ok_row         (ok_row),
    .rcol           (rcol),
    .pcol           (pcol),
    .rrow           (rrow),
    .prow           (prow),
    .num_cols       (num_cols),
    .valid_res      (m_tuser),
    .cell_nearest   (m_tdata[EW-1:0]),
    .cell_vertical  (m_tdata[2*EW-1:EW]),
    .cell_diagonal  (m_tdata[3*EW-1:2*EW]),
    .cell_horizontal(m_tdata[4*EW-1:3*EW])
  );

endmodule

// ----- rtl/nbc_check.sv -----
`timescale 1ns / 1ps

module nbc_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [4*nbc_pkg::CELL_W-1:0] m_tdata,
  input logic                         m_tuser
);

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A point off the grid reports no cells.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("invalid result carries nonzero cells");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present right after reset");

  // Input is refused only when the pipeline is full up to a waiting result.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input refused with room in the pipeline");

endmodule

bind four_neighbor_cells_from_point nbc_check u_nbc_check (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
